### design/aca_pkg.sv
// Shared constants and controller/datapath interface types for the core assigner.
package aca_pkg;

    // Fixed field widths of the stream words
    localparam int JOB_W      = 8;
    localparam int PREV_W     = 3;
    localparam int CORE_NUM_W = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;

    // Bit positions in s_tdata
    localparam int S_RUN_BIT  = JOB_W;
    localparam int S_HASP_BIT = JOB_W + 1;
    localparam int S_PREV_LSB = JOB_W + 2;

    // Bit positions in m_tuser
    localparam int M_BUSY_BIT = 0;
    localparam int M_OVF_BIT  = 1;

    typedef struct packed {
        logic load;     // store the accepted input word
        logic clear;    // empty every core
        logic pass1;    // put a running job back on its core
        logic pass2;    // place one remaining job
        logic emit;     // load the output register with one core result
        logic finish;   // drop the set
    } cmd_t;

    typedef struct packed {
        logic ovf_pending;  // set already overflowed, or this word overflows it
        logic last_step;    // step index points at the final stored job
        logic out_free;     // output register can take a new word
    } stat_t;

endpackage

### design/aca_ctrl.sv
// Controller state machine: load, two placement passes, per-core emit.
module aca_ctrl
    import aca_pkg::*;
#(
    parameter int NUM_CORES = 8,
    parameter int CW        = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tlast,
    input  stat_t         stat,
    output cmd_t          cmd,
    output logic [CW-1:0] step_idx,
    output logic [CW-1:0] core_idx
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] c_reg, c_next;
    logic          accept;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign step_idx = i_reg;
    assign core_idx = c_reg;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        c_next     = c_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.clear = 1'b1;
                        i_next    = '0;
                        c_next    = '0;
                        state_next = stat.ovf_pending ? ST_EMIT : ST_PASS1;
                    end
                end
            end
            ST_PASS1: begin
                cmd.pass1 = 1'b1;
                if (stat.last_step) begin
                    i_next     = '0;
                    state_next = ST_PASS2;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_PASS2: begin
                cmd.pass2 = 1'b1;
                if (stat.last_step) begin
                    c_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (c_reg == CW'(NUM_CORES - 1)) begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            c_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            c_reg     <= c_next;
        end
    end

endmodule

### design/aca_dp.sv
// Datapath: sorted job buffer, core table, and the result output register.
module aca_dp
    import aca_pkg::*;
#(
    parameter int NUM_CORES   = 8,
    parameter int JOB_ID_BITS = 8,
    parameter int CW          = 3,
    parameter int CNW         = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    input  logic [CW-1:0]        step_idx,
    input  logic [CW-1:0]        core_idx,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output stat_t                stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    typedef struct packed {
        logic [JOB_ID_BITS-1:0] id;
        logic                   run;
        logic                   hasp;
        logic [PREV_W-1:0]      prev;
    } entry_t;

    entry_t                 jbuf_reg [NUM_CORES];
    logic [CNW-1:0]         count_reg;
    logic                   ovf_reg;
    logic [NUM_CORES-1:0]   busy_reg;
    logic [NUM_CORES-1:0]   pin_reg;
    logic [JOB_ID_BITS-1:0] occ_reg [NUM_CORES];

    entry_t               new_e;
    entry_t               src [NUM_CORES];
    logic [NUM_CORES-1:0] gt;
    logic [NUM_CORES-1:0] wr;
    logic                 full;

    // ---------------- insertion into the sorted buffer ----------------
    assign new_e.id   = JOB_ID_BITS'(s_tdata[JOB_W-1:0]);
    assign new_e.run  = s_tdata[S_RUN_BIT];
    assign new_e.hasp = s_tdata[S_HASP_BIT];
    assign new_e.prev = s_tdata[S_PREV_LSB +: PREV_W];

    assign full = (count_reg == CNW'(NUM_CORES));

    for (genvar k = 0; k < NUM_CORES; k++) begin : g_ins
        assign gt[k] = (CNW'(k) < count_reg) && (jbuf_reg[k].id > new_e.id);
        assign wr[k] = cmd.load && !full && (gt[k] || (CNW'(k) == count_reg));
        if (k == 0) begin : g_first
            assign src[k] = new_e;
        end else begin : g_rest
            // shift up one slot behind the insertion point
            assign src[k] = gt[k-1] ? jbuf_reg[k-1] : new_e;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_CORES; k++) begin
            if (wr[k]) begin
                jbuf_reg[k] <= src[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.finish) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (full) begin
                ovf_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + CNW'(1);
            end
        end
    end

    // ---------------- placement passes ----------------
    entry_t                 cur;
    logic                   hv;
    logic [CW-1:0]          pc;
    logic [CW-1:0]          lo_idx;
    logic                   lo_found;
    logic                   wa_en, wb_en;
    logic [CW-1:0]          wa_idx, wb_idx;
    logic [JOB_ID_BITS-1:0] wa_id, wb_id;

    assign cur = jbuf_reg[step_idx];
    assign hv  = cur.hasp && (int'(cur.prev) < NUM_CORES);
    assign pc  = CW'(cur.prev);

    // lowest empty core
    always_comb begin
        lo_idx   = '0;
        lo_found = 1'b0;
        for (int k = NUM_CORES - 1; k >= 0; k--) begin
            if (!busy_reg[k]) begin
                lo_idx   = CW'(k);
                lo_found = 1'b1;
            end
        end
    end

    // port a writes a job onto its own core (pinned), port b onto the lowest empty core
    always_comb begin
        wa_en  = 1'b0;
        wa_idx = pc;
        wa_id  = cur.id;
        wb_en  = 1'b0;
        wb_idx = lo_idx;
        wb_id  = cur.id;
        if (cmd.pass1) begin
            wa_en = cur.run && hv;
        end else if (cmd.pass2 && !(cur.run && hv)) begin
            priority if (hv && !busy_reg[pc]) begin
                wa_en = 1'b1;
            end else if (hv && !pin_reg[pc]) begin
                // swap: displaced occupant moves to the lowest empty core
                wa_en = 1'b1;
                wb_en = lo_found;
                wb_id = occ_reg[pc];
            end else begin
                wb_en = lo_found;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else if (cmd.clear) begin
            busy_reg <= '0;
        end else begin
            if (wa_en) begin
                busy_reg[wa_idx] <= 1'b1;
            end
            if (wb_en) begin
                busy_reg[wb_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wa_en) begin
            occ_reg[wa_idx] <= wa_id;
            pin_reg[wa_idx] <= 1'b1;
        end
        if (wb_en) begin
            occ_reg[wb_idx] <= wb_id;
            pin_reg[wb_idx] <= 1'b0;
        end
    end

    // ---------------- output register ----------------
    logic                  m_tvalid_reg;
    logic [CORE_NUM_W-1:0] o_core_reg;
    logic                  o_busy_reg;
    logic [JOB_W-1:0]      o_job_reg;
    logic                  o_ovf_reg;
    logic                  o_last_reg;
    logic                  busy_now;

    assign busy_now = !ovf_reg && busy_reg[core_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            o_core_reg <= CORE_NUM_W'(core_idx);
            o_busy_reg <= busy_now;
            o_job_reg  <= busy_now ? JOB_W'(occ_reg[core_idx]) : '0;
            o_ovf_reg  <= ovf_reg;
            o_last_reg <= (core_idx == CW'(NUM_CORES - 1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({o_job_reg, o_core_reg});
    assign m_tuser  = {o_ovf_reg, o_busy_reg};
    assign m_tlast  = o_last_reg;

    // ---------------- status ----------------
    assign stat.ovf_pending = ovf_reg || full;
    assign stat.last_step   = ((CNW'(step_idx) + CNW'(1)) == count_reg);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule

### design/affinity_core_assigner_core.sv
// Top level of the affinity-aware core assigner.
//
// Input stream: one word per chosen job; s_tlast marks the final job of a set.
// Jobs are inserted into an index-sorted buffer as they arrive, one word per
// cycle. After the last word the block walks the stored jobs twice, one job per
// cycle: first putting running jobs back on their own cores, then placing the
// rest on their previous core, swapping out an unpinned occupant, or on the
// lowest empty core. It then emits NUM_CORES result words, lowest core first,
// with m_tlast on the final core.
// Both passes use the single shared placement step, and results leave one core
// at a time through the output register.
// More than NUM_CORES jobs in a set skips the passes: every result then shows
// overflow with no core busy.
// s_tready is low from the last input word until the final result of the set
// has been loaded into the output register; the output register holds its word
// while m_tready is low, and emission simply waits.
// Reset (aresetn low, synchronous) empties the set and the core table and
// drops any pending result word.
module affinity_core_assigner_core
    import aca_pkg::*;
#(
    parameter int NUM_CORES   = 8,
    parameter int JOB_ID_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] job_index, [8] is_running, [9] has_home, [12:10] home_core
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] core_number, [10:3] assigned_job
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] core_busy, [1] overflow
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int CW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CNW = $clog2(NUM_CORES + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [CW-1:0] step_idx;
    logic [CW-1:0] core_idx;

    aca_ctrl #(
        .NUM_CORES (NUM_CORES),
        .CW        (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd),
        .step_idx (step_idx),
        .core_idx (core_idx)
    );

    aca_dp #(
        .NUM_CORES   (NUM_CORES),
        .JOB_ID_BITS (JOB_ID_BITS),
        .CW          (CW),
        .CNW         (CNW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .step_idx (step_idx),
        .core_idx (core_idx),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // an overflowed set never reports a busy core
    a_ovf_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[M_OVF_BIT] |-> !m_tuser[M_BUSY_BIT])
        else $error("overflow word reports a busy core");

    // the final result word describes the highest core
    a_last_core: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[CORE_NUM_W-1:0] == CORE_NUM_W'(NUM_CORES - 1))
        else $error("last word carries wrong core number");

    // input closes after the final job of a set
    a_close_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after final job");
`endif

endmodule

### dv/aca_checker.sv
// Stream monitor for the core assigner: predicts every core result and compares it.
module aca_checker
    import aca_pkg::*;
#(
    parameter int NCORES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    results_due_left,
    output int                    jobs_seen,
    output int                    sets_seen,
    output int                    overflow_sets,
    output int                    swaps_seen,
    output int                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [JOB_W-1:0]  idx;
        bit                run;
        bit                has_prev;
        logic [PREV_W-1:0] prev;
    } job_t;

    typedef struct {
        bit   busy;
        job_t occ;
    } core_slot_t;

    typedef struct {
        logic [CORE_NUM_W-1:0] core;
        bit                    busy;
        logic [JOB_W-1:0]      job;
        bit                    ovf;
        bit                    last;
    } core_result_t;

    job_t         pending_jobs[NCORES];
    int           pending_count;
    bit           pending_overflow;
    core_slot_t   core_map[NCORES];
    core_result_t core_results_due[$];

    initial begin
        fail_count       = 0;
        results_due_left = 0;
        jobs_seen        = 0;
        sets_seen        = 0;
        overflow_sets    = 0;
        swaps_seen       = 0;
        results_checked  = 0;
        pending_count    = 0;
        pending_overflow = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit has_home(input job_t j);
        return j.has_prev && (int'(j.prev) < NCORES);
    endfunction

    function automatic void take_lowest_free(input job_t j);
        for (int c = 0; c < NCORES; c++) begin
            if (!core_map[c].busy) begin
                core_map[c].busy = 1'b1;
                core_map[c].occ  = j;
                return;
            end
        end
    endfunction

    // Stable sort by index, pin running jobs, then place the rest.
    function automatic void place_jobs();
        int   order[NCORES];
        int   j;
        int   home;
        job_t cur;
        job_t moved;
        for (int i = 0; i < pending_count; i++) begin
            j = i;
            while (j > 0 && pending_jobs[order[j-1]].idx > pending_jobs[i].idx) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int c = 0; c < NCORES; c++)
            core_map[c].busy = 1'b0;
        for (int i = 0; i < pending_count; i++) begin
            cur = pending_jobs[order[i]];
            if (cur.run && has_home(cur)) begin
                core_map[cur.prev].busy = 1'b1;
                core_map[cur.prev].occ  = cur;
            end
        end
        for (int i = 0; i < pending_count; i++) begin
            cur = pending_jobs[order[i]];
            if (!(cur.run && has_home(cur))) begin
                if (has_home(cur) && !core_map[cur.prev].busy) begin
                    core_map[cur.prev].busy = 1'b1;
                    core_map[cur.prev].occ  = cur;
                end else begin
                    if (has_home(cur)) begin
                        home = int'(cur.prev);
                        // evict an occupant that is not on its own home core
                        if (!(has_home(core_map[home].occ) &&
                              int'(core_map[home].occ.prev) == home)) begin
                            moved               = core_map[home].occ;
                            core_map[home].occ  = cur;
                            cur                 = moved;
                            swaps_seen++;
                        end
                    end
                    take_lowest_free(cur);
                end
            end
        end
    endfunction

    function automatic void accept_job();
        core_result_t r;
        jobs_seen++;
        if (pending_count < NCORES) begin
            pending_jobs[pending_count].idx      = s_tdata[JOB_W-1:0];
            pending_jobs[pending_count].run      = s_tdata[S_RUN_BIT];
            pending_jobs[pending_count].has_prev = s_tdata[S_HASP_BIT];
            pending_jobs[pending_count].prev     = s_tdata[S_PREV_LSB +: PREV_W];
            pending_count++;
        end else begin
            pending_overflow = 1'b1;
        end
        if (s_tlast) begin
            sets_seen++;
            if (pending_overflow) begin
                overflow_sets++;
                for (int c = 0; c < NCORES; c++)
                    core_map[c].busy = 1'b0;
            end else begin
                place_jobs();
            end
            for (int c = 0; c < NCORES; c++) begin
                r.core = CORE_NUM_W'(c);
                r.busy = !pending_overflow && core_map[c].busy;
                r.job  = r.busy ? core_map[c].occ.idx : '0;
                r.ovf  = pending_overflow;
                r.last = (c == NCORES - 1);
                core_results_due.push_back(r);
            end
            pending_count    = 0;
            pending_overflow = 1'b0;
        end
    endfunction

    task automatic check_core_result();
        core_result_t want;
        logic [CORE_NUM_W-1:0] got_core;
        logic [JOB_W-1:0]      got_job;
        got_core = m_tdata[CORE_NUM_W-1:0];
        got_job  = m_tdata[CORE_NUM_W +: JOB_W];
        if (core_results_due.size() == 0) begin
            report_mismatch($sformatf("result word for core %0d with nothing expected",
                                      got_core));
            return;
        end
        want = core_results_due.pop_front();
        results_checked++;
        if (got_core !== want.core)
            report_mismatch($sformatf("core_number %0d, expected %0d", got_core, want.core));
        if (m_tuser[M_BUSY_BIT] !== want.busy)
            report_mismatch($sformatf("core %0d core_busy %b, expected %b",
                                      want.core, m_tuser[M_BUSY_BIT], want.busy));
        if (got_job !== want.job)
            report_mismatch($sformatf("core %0d assigned_job %0d, expected %0d",
                                      want.core, got_job, want.job));
        if (m_tuser[M_OVF_BIT] !== want.ovf)
            report_mismatch($sformatf("core %0d overflow %b, expected %b",
                                      want.core, m_tuser[M_OVF_BIT], want.ovf));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("core %0d last_core %b, expected %b",
                                      want.core, m_tlast, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_count    = 0;
            pending_overflow = 1'b0;
            core_results_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                accept_job();
            if (m_tvalid && m_tready)
                check_core_result();
        end
        results_due_left = core_results_due.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the core assigner: reset, job set stimulus, back-pressure and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aca_pkg::*;

    localparam int NCORES       = 8;
    localparam int JOB_TARGET   = 270;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int fail_count, results_due_left, jobs_seen, sets_seen;
    int overflow_sets, swaps_seen, results_checked;

    int jobs_sent   = 0;
    int ready_hold  = 0;
    int ready_draw;
    int quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    affinity_core_assigner_core #(
        .NUM_CORES   (NCORES),
        .JOB_ID_BITS (8)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    aca_checker #(.NCORES(NCORES)) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .fail_count       (fail_count),
        .results_due_left (results_due_left),
        .jobs_seen        (jobs_seen),
        .sets_seen        (sets_seen),
        .overflow_sets    (overflow_sets),
        .swaps_seen       (swaps_seen),
        .results_checked  (results_checked)
    );

    // Result side back-pressure: ready runs, short stalls, rare long stalls.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_draw = $urandom_range(0, 99);
            if (ready_draw < 5) begin
                m_tready   <= 1'b1;
                ready_hold <= 100;
            end else if (ready_draw < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 7);
            end else if (ready_draw < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Hold the word until the block takes it.
    task automatic send_job(input logic [JOB_W-1:0] idx, input bit run, input bit has_prev,
                            input logic [PREV_W-1:0] prev, input bit last, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({prev, has_prev, run, idx});
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        jobs_sent++;
    endtask

    initial begin
        int  set_len;
        bit  crowded;
        bit  no_gaps;
        logic [JOB_W-1:0] idx;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // single running job on the top core, highest index
        send_job(8'd255, 1'b1, 1'b1, 3'd7, 1'b1, pick_gap());

        // full set: two runners on one core, equal indices, runner without home,
        // swap of an unpinned occupant, pinned occupant forcing lowest core
        send_job(8'd9,   1'b1, 1'b1, 3'd3, 1'b0, pick_gap());
        send_job(8'd5,   1'b1, 1'b1, 3'd3, 1'b0, pick_gap());
        send_job(8'd200, 1'b1, 1'b0, 3'd6, 1'b0, pick_gap());
        send_job(8'd17,  1'b0, 1'b1, 3'd2, 1'b0, pick_gap());
        send_job(8'd5,   1'b0, 1'b1, 3'd2, 1'b0, pick_gap());
        send_job(8'd0,   1'b0, 1'b0, 3'd0, 1'b0, pick_gap());
        send_job(8'd100, 1'b0, 1'b1, 3'd6, 1'b0, pick_gap());
        send_job(8'd4,   1'b0, 1'b1, 3'd0, 1'b1, pick_gap());

        // one job too many
        for (int k = 0; k < NCORES + 1; k++)
            send_job(k[0] ? 8'hAA : 8'h55, k[1], k[0], 3'(k), k == NCORES, pick_gap());

        // runner pins core 7, a job homed there falls to the lowest free core
        send_job(8'd3,   1'b0, 1'b1, 3'd7, 1'b0, pick_gap());
        send_job(8'd1,   1'b1, 1'b1, 3'd7, 1'b0, pick_gap());
        send_job(8'd2,   1'b0, 1'b1, 3'd5, 1'b0, pick_gap());
        send_job(8'h80,  1'b1, 1'b0, 3'd4, 1'b1, pick_gap());

        while (jobs_sent < JOB_TARGET) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(NCORES + 1, NCORES + 4)
                                                  : $urandom_range(1, NCORES);
            crowded = ($urandom_range(0, 2) == 0);
            no_gaps = ($urandom_range(0, 6) == 0);
            for (int k = 0; k < set_len; k++) begin
                idx = crowded ? JOB_W'($urandom_range(0, 7)) : JOB_W'($urandom);
                send_job(idx, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                         PREV_W'($urandom_range(0, 7)), k == set_len - 1,
                         no_gaps ? 0 : pick_gap());
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the monitor take in the final word before polling its queue
        @(posedge aclk);
        while (results_due_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d job words in %0d sets, %0d of them overflowing, %0d swaps",
                 jobs_seen, sets_seen, overflow_sets, swaps_seen);
        $display("compared %0d core results, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
design/aca_pkg.sv
design/aca_ctrl.sv
design/aca_dp.sv
design/affinity_core_assigner_core.sv
dv/aca_checker.sv
dv/tb.sv
